// File: rtl/dcsort_pkg.sv
// ----------------------------------------------------------------------------
// dcsort_pkg
// Shared types, codes and helpers for the draw-op cull and sort unit.
// ----------------------------------------------------------------------------
package dcsort_pkg;

	localparam int MAX_OPS_DEF = 32;
	localparam int MIN_CULL    = 2;

	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_OPT = 2'd1;
	localparam logic [1:0] ACT_CLR = 2'd2;

	localparam logic [1:0] REG_DX = 2'd0;
	localparam logic [1:0] REG_DY = 2'd1;
	localparam logic [1:0] REG_DW = 2'd2;
	localparam logic [1:0] REG_DH = 2'd3;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        w;
		logic [15:0]        h;
	} rect_t;

	typedef struct packed {
		logic signed [15:0] depth;
		logic [15:0]        source;
	} key_t;

	typedef struct packed {
		rect_t       rect;
		key_t        key;
		logic [15:0] tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic key_less(key_t a, key_t b);
		logic res;
		if (a.depth != b.depth) begin
			res = (a.depth < b.depth);
		end else begin
			res = (a.source < b.source);
		end
		return res;
	endfunction

	function automatic logic overlaps(rect_t a, rect_t b);
		logic signed [17:0] ax, ay, bx, by, ax_end, ay_end, bx_end, by_end;
		logic res;
		ax = {{2{a.x[15]}}, a.x};
		ay = {{2{a.y[15]}}, a.y};
		bx = {{2{b.x[15]}}, b.x};
		by = {{2{b.y[15]}}, b.y};
		ax_end = ax + $signed({2'b00, a.w});
		ay_end = ay + $signed({2'b00, a.h});
		bx_end = bx + $signed({2'b00, b.w});
		by_end = by + $signed({2'b00, b.h});
		if (a.w == 16'd0 || a.h == 16'd0 || b.w == 16'd0 || b.h == 16'd0) begin
			res = 1'b0;
		end else begin
			res = !(ax_end <= bx || bx_end <= ax || ay_end <= by || by_end <= ay);
		end
		return res;
	endfunction

endpackage

// File: rtl/dcsort_ram.sv
// ----------------------------------------------------------------------------
// dcsort_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dcsort_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/draw_op_cull_and_sort_unit.sv
// ----------------------------------------------------------------------------
// draw_op_cull_and_sort_unit
// Holds draw ops in one RAM; on optimize culls against the dirty region,
// exchange-sorts by (depth, source) and streams the list out.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             word
//  in       input      in_valid / in_stall   action + op fields
//  out      output     out_valid / out_stall op fields + is_last/list_empty/overflowed
//  cfg      input      cfg_write             cfg_index + cfg_data
//
//  Add and clear are taken in idle. Optimize with n ops: cull pass (when
//  active), setup state, sort (n >= 2) through the RAM read/write port pair,
//  then emit, each word via S_EMIT and S_EMIT_WAIT and held by output stalls.
//  Reset clears count, drop flag, registers and control; RAM needs no clear.
//  Input stalls outside idle, and an optimize stalls while a word still waits.
// ----------------------------------------------------------------------------
module draw_op_cull_and_sort_unit #(
	parameter int MAX_OPS = dcsort_pkg::MAX_OPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic signed [15:0] rect_x,
	input  logic signed [15:0] rect_y,
	input  logic [15:0]        rect_width,
	input  logic [15:0]        rect_height,
	input  logic signed [15:0] depth_order,
	input  logic [15:0]        source_id,
	input  logic [15:0]        op_tag,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        out_tag,
	output logic signed [15:0] out_depth_order,
	output logic [15:0]        out_source_id,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic [15:0]        out_width,
	output logic [15:0]        out_height,
	output logic               is_last,
	output logic               list_empty,
	output logic               overflowed
);

	localparam int AW = $clog2(MAX_OPS);
	localparam int CW = $clog2(MAX_OPS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_CULL, S_PREP, S_SORT_LD, S_SORT_LDW, S_SORT_SCAN, S_SORT_ST,
		S_EMIT, S_EMIT_WAIT
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q, rd_q, w_q, i_q, j_q, e_q;
	logic          pend_q, drop_q, out_valid_q;
	dcsort_pkg::entry_t cur_q;
	dcsort_pkg::rect_t  dirty_q;

	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	dcsort_pkg::entry_t  ram_wdata, ram_rdata, in_entry;
	logic                in_acc, keep, less, out_free, cull_on;
	logic [CW-1:0]       j_next;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && action == dcsort_pkg::ACT_OPT);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign keep     = dcsort_pkg::overlaps(ram_rdata.rect, dirty_q);
	assign less     = dcsort_pkg::key_less(ram_rdata.key, cur_q.key);
	assign j_next   = j_q + CW'(1);
	assign cull_on  = (count_q >= CW'(dcsort_pkg::MIN_CULL)) && (dirty_q.w != 16'd0)
	                  && (dirty_q.h != 16'd0);

	always_comb begin
		in_entry.rect.x     = rect_x;
		in_entry.rect.y     = rect_y;
		in_entry.rect.w     = rect_width;
		in_entry.rect.h     = rect_height;
		in_entry.key.depth  = depth_order;
		in_entry.key.source = source_id;
		in_entry.tag        = op_tag;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = cur_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (in_acc && action == dcsort_pkg::ACT_ADD && count_q < CW'(MAX_OPS)) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[AW-1:0];
					ram_wdata = in_entry;
				end
			end
			S_CULL: begin
				if (pend_q && keep) begin
					ram_we    = 1'b1;
					ram_waddr = w_q[AW-1:0];
					ram_wdata = ram_rdata;
				end
				if (rd_q < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = rd_q[AW-1:0];
				end
			end
			S_SORT_LD: begin
				ram_re    = 1'b1;
				ram_raddr = i_q[AW-1:0];
			end
			S_SORT_LDW: begin
				ram_re    = 1'b1;
				ram_raddr = j_q[AW-1:0];
			end
			S_SORT_SCAN: begin
				if (less) begin
					ram_we    = 1'b1;
					ram_waddr = j_q[AW-1:0];
				end
				if (j_next < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = j_next[AW-1:0];
				end
			end
			S_SORT_ST: begin
				ram_we    = 1'b1;
				ram_waddr = i_q[AW-1:0];
			end
			S_EMIT: begin
				if (out_free && count_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = e_q[AW-1:0];
				end
			end
			default: ;
		endcase
	end

	dcsort_ram #(
		.WIDTH (dcsort_pkg::ENTRY_W),
		.DEPTH (MAX_OPS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				dcsort_pkg::REG_DX: dirty_q.x <= cfg_data;
				dcsort_pkg::REG_DY: dirty_q.y <= cfg_data;
				dcsort_pkg::REG_DW: dirty_q.w <= cfg_data;
				dcsort_pkg::REG_DH: dirty_q.h <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			count_q         <= '0;
			drop_q          <= 1'b0;
			pend_q          <= 1'b0;
			rd_q            <= '0;
			w_q             <= '0;
			i_q             <= '0;
			j_q             <= '0;
			e_q             <= '0;
			cur_q           <= '0;
			out_valid_q     <= 1'b0;
			out_tag         <= '0;
			out_depth_order <= '0;
			out_source_id   <= '0;
			out_x           <= '0;
			out_y           <= '0;
			out_width       <= '0;
			out_height      <= '0;
			is_last         <= 1'b0;
			list_empty      <= 1'b0;
			overflowed      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (action)
							dcsort_pkg::ACT_ADD: begin
								if (count_q < CW'(MAX_OPS)) begin
									count_q <= count_q + CW'(1);
								end else begin
									drop_q <= 1'b1;
								end
							end
							dcsort_pkg::ACT_CLR: begin
								count_q <= '0;
								drop_q  <= 1'b0;
							end
							dcsort_pkg::ACT_OPT: begin
								rd_q    <= '0;
								w_q     <= '0;
								pend_q  <= 1'b0;
								state_q <= cull_on ? S_CULL : S_PREP;
							end
							default: ;
						endcase
					end
				end
				S_CULL: begin
					if (rd_q < count_q) begin
						rd_q   <= rd_q + CW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && keep) begin
						w_q <= w_q + CW'(1);
					end
					if (pend_q && rd_q >= count_q) begin
						count_q <= w_q + CW'(keep);
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					i_q <= '0;
					e_q <= '0;
					state_q <= (count_q >= CW'(dcsort_pkg::MIN_CULL)) ? S_SORT_LD : S_EMIT;
				end
				S_SORT_LD: begin
					j_q     <= i_q + CW'(1);
					state_q <= S_SORT_LDW;
				end
				S_SORT_LDW: begin
					cur_q   <= ram_rdata;
					state_q <= S_SORT_SCAN;
				end
				S_SORT_SCAN: begin
					if (less) begin
						cur_q <= ram_rdata;
					end
					if (j_next < count_q) begin
						j_q <= j_next;
					end else begin
						state_q <= S_SORT_ST;
					end
				end
				S_SORT_ST: begin
					i_q     <= i_q + CW'(1);
					state_q <= ((i_q + CW'(2)) < count_q) ? S_SORT_LD : S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (count_q == '0) begin
							out_valid_q     <= 1'b1;
							out_tag         <= '0;
							out_depth_order <= '0;
							out_source_id   <= '0;
							out_x           <= '0;
							out_y           <= '0;
							out_width       <= '0;
							out_height      <= '0;
							is_last         <= 1'b1;
							list_empty      <= 1'b1;
							overflowed      <= drop_q;
							state_q         <= S_IDLE;
						end else begin
							out_valid_q <= 1'b0;
							state_q     <= S_EMIT_WAIT;
						end
					end
				end
				S_EMIT_WAIT: begin
					out_valid_q     <= 1'b1;
					out_tag         <= ram_rdata.tag;
					out_depth_order <= ram_rdata.key.depth;
					out_source_id   <= ram_rdata.key.source;
					out_x           <= ram_rdata.rect.x;
					out_y           <= ram_rdata.rect.y;
					out_width       <= ram_rdata.rect.w;
					out_height      <= ram_rdata.rect.h;
					is_last         <= (e_q + CW'(1) == count_q);
					list_empty      <= 1'b0;
					overflowed      <= drop_q;
					e_q             <= e_q + CW'(1);
					state_q         <= (e_q + CW'(1) == count_q) ? S_IDLE : S_EMIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_OPS))
		else $error("entry count above capacity");

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re && state_q != S_IDLE) |-> ram_waddr != ram_raddr)
		else $error("RAM read and write hit the same entry");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && list_empty) |-> is_last)
		else $error("empty-list word not marked last");

	a_opt_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action == dcsort_pkg::ACT_OPT) |=> state_q != S_IDLE)
		else $error("optimize accepted but no pass started");

	a_emit_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_WAIT) |-> !out_valid_q)
		else $error("result word overwritten before taken");

endmodule

// File: bench/draw_op_cull_and_sort_unit_test.sv
// ----------------------------------------------------------------------------
// draw_op_cull_and_sort_unit_test
// Self-checking bench for the draw-op cull and sort unit. A directed table
// covers field extremes, every action, edge-touching and zero-size rectangles,
// equal sort keys, single-op optimize and a fully culled list. Random phases
// follow, each reprogramming the dirty region and loading a batch of ops
// before an optimize; one phase overfills the store. Every output word is
// compared with a typed result or a behavioral copy of cull and exchange sort.
// ----------------------------------------------------------------------------
module draw_op_cull_and_sort_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int OP_SLOTS = dcsort_pkg::MAX_OPS_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 100;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        w;
		logic [15:0]        h;
		logic signed [15:0] depth;
		logic [15:0]        source;
		logic [15:0]        tag;
	} draw_op_t;

	typedef struct packed {
		logic [1:0] act;
		draw_op_t   op;
	} command_t;

	typedef struct packed {
		logic [15:0]        tag;
		logic signed [15:0] depth;
		logic [15:0]        source;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        w;
		logic [15:0]        h;
		logic               last;
		logic               empty;
		logic               ovf;
	} list_word_t;

	typedef struct packed {
		bit         is_reg;
		logic [1:0] reg_idx;
		logic [15:0] reg_val;
		command_t   cmd;
		bit         typed;
		list_word_t res;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         action;
	logic signed [15:0] rect_x;
	logic signed [15:0] rect_y;
	logic [15:0]        rect_width;
	logic [15:0]        rect_height;
	logic signed [15:0] depth_order;
	logic [15:0]        source_id;
	logic [15:0]        op_tag;
	logic               out_valid;
	logic               out_stall;
	logic [15:0]        out_tag;
	logic signed [15:0] out_depth_order;
	logic [15:0]        out_source_id;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic [15:0]        out_width;
	logic [15:0]        out_height;
	logic               is_last;
	logic               list_empty;
	logic               overflowed;

	draw_op_cull_and_sort_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.rect_x(rect_x), .rect_y(rect_y), .rect_width(rect_width),
		.rect_height(rect_height), .depth_order(depth_order),
		.source_id(source_id), .op_tag(op_tag),
		.out_valid(out_valid), .out_stall(out_stall), .out_tag(out_tag),
		.out_depth_order(out_depth_order), .out_source_id(out_source_id),
		.out_x(out_x), .out_y(out_y), .out_width(out_width),
		.out_height(out_height), .is_last(is_last), .list_empty(list_empty),
		.overflowed(overflowed)
	);

	draw_op_t           held_ops[$];
	bit                 ops_dropped = 1'b0;
	logic signed [15:0] dirty_x_r = '0;
	logic signed [15:0] dirty_y_r = '0;
	logic [15:0]        dirty_w_r = '0;
	logic [15:0]        dirty_h_r = '0;
	list_word_t         fresh_words[$];
	list_word_t         expected_words[$];
	bit                 typed_on;
	list_word_t         typed_res;
	int                 errors = 0;
	int                 idle_cycles = 0;
	int                 tx_max = 12;
	int                 rx_max = 12;
	plan_row_t          plan[$];

	function automatic bit rect_in_dirty(draw_op_t op);
		int ax, ay, aw, ah, bx, by, bw, bh;
		ax = op.x;
		ay = op.y;
		aw = op.w;
		ah = op.h;
		bx = dirty_x_r;
		by = dirty_y_r;
		bw = dirty_w_r;
		bh = dirty_h_r;
		if (aw == 0 || ah == 0 || bw == 0 || bh == 0) begin
			return 1'b0;
		end
		return !(ax + aw <= bx || bx + bw <= ax || ay + ah <= by || by + bh <= ay);
	endfunction

	function automatic bit key_precedes(draw_op_t a, draw_op_t b);
		if (a.depth != b.depth) begin
			return a.depth < b.depth;
		end
		return a.source < b.source;
	endfunction

	function automatic void predict_list(command_t c);
		draw_op_t   kept[$];
		draw_op_t   t;
		list_word_t r;
		fresh_words.delete();
		case (c.act)
			dcsort_pkg::ACT_ADD: begin
				if (held_ops.size() >= OP_SLOTS) begin
					ops_dropped = 1'b1;
				end else begin
					held_ops.insert(held_ops.size(), c.op);
				end
			end
			dcsort_pkg::ACT_CLR: begin
				held_ops.delete();
				ops_dropped = 1'b0;
			end
			dcsort_pkg::ACT_OPT: begin
				if (held_ops.size() >= dcsort_pkg::MIN_CULL && dirty_w_r != 0
					&& dirty_h_r != 0) begin
					foreach (held_ops[i]) begin
						if (rect_in_dirty(held_ops[i])) begin
							kept.insert(kept.size(), held_ops[i]);
						end
					end
					held_ops = kept;
				end
				for (int i = 0; i < held_ops.size(); i++) begin
					for (int j = i + 1; j < held_ops.size(); j++) begin
						if (key_precedes(held_ops[j], held_ops[i])) begin
							t = held_ops[i];
							held_ops[i] = held_ops[j];
							held_ops[j] = t;
						end
					end
				end
				if (held_ops.size() == 0) begin
					r = '0;
					r.last = 1'b1;
					r.empty = 1'b1;
					r.ovf = ops_dropped;
					fresh_words.insert(fresh_words.size(), r);
				end
				foreach (held_ops[i]) begin
					r = '{held_ops[i].tag, held_ops[i].depth, held_ops[i].source,
						held_ops[i].x, held_ops[i].y, held_ops[i].w, held_ops[i].h,
						i == held_ops.size() - 1, 1'b0, ops_dropped};
					fresh_words.insert(fresh_words.size(), r);
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic string show(list_word_t v);
		return $sformatf("tag=%h z=%h src=%h x=%h y=%h w=%h h=%h last=%b empty=%b ovf=%b",
			v.tag, v.depth, v.source, v.x, v.y, v.w, v.h, v.last, v.empty, v.ovf);
	endfunction

	function automatic void note_error(string msg);
		errors++;
		if (errors <= 10) begin
			$display("%s", msg);
		end
	endfunction

	function automatic plan_row_t word_row(logic [1:0] a, int x, int y, int w, int h,
		int z, int s, int t);
		plan_row_t r;
		r = '0;
		r.cmd.act = a;
		r.cmd.op = '{16'(x), 16'(y), 16'(w), 16'(h), 16'(z), 16'(s), 16'(t)};
		return r;
	endfunction

	function automatic plan_row_t reg_row(logic [1:0] idx, int v);
		plan_row_t r;
		r = '0;
		r.is_reg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = 16'(v);
		return r;
	endfunction

	// optimize whose single word is the empty-list marker
	function automatic plan_row_t empty_opt_row(bit ovf);
		plan_row_t r;
		r = word_row(dcsort_pkg::ACT_OPT, 0, 0, 0, 0, 0, 0, 0);
		r.typed = 1'b1;
		r.res.last = 1'b1;
		r.res.empty = 1'b1;
		r.res.ovf = ovf;
		return r;
	endfunction

	function automatic void queue_row(plan_row_t r);
		plan.insert(plan.size(), r);
	endfunction

	function automatic draw_op_t rand_op(bit wide);
		draw_op_t o;
		if (wide) begin
			o = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom)};
		end else begin
			o.x = 16'($urandom_range(0, 400) - 200);
			o.y = 16'($urandom_range(0, 400) - 200);
			o.w = 16'($urandom_range(0, 150));
			o.h = 16'($urandom_range(0, 150));
			o.depth = 16'($urandom_range(0, 4) - 2);
			o.source = 16'($urandom_range(0, 3));
			o.tag = 16'($urandom);
		end
		return o;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin : monitor
		list_word_t got, want;
		command_t   c;
		bit         moved;
		if (arst_n) begin
			moved = cfg_write;
			if (cfg_write) begin
				case (cfg_index)
					dcsort_pkg::REG_DX: dirty_x_r = cfg_data;
					dcsort_pkg::REG_DY: dirty_y_r = cfg_data;
					dcsort_pkg::REG_DW: dirty_w_r = cfg_data;
					dcsort_pkg::REG_DH: dirty_h_r = cfg_data;
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				got = '{out_tag, out_depth_order, out_source_id, out_x, out_y,
					out_width, out_height, is_last, list_empty, overflowed};
				if (expected_words.size() == 0) begin
					note_error($sformatf("unexpected word: %s", show(got)));
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						note_error($sformatf("mismatch\n  exp %s\n  got %s",
							show(want), show(got)));
					end
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				c.act = action;
				c.op = '{rect_x, rect_y, rect_width, rect_height, depth_order,
					source_id, op_tag};
				predict_list(c);
				if (typed_on) begin
					expected_words.insert(expected_words.size(), typed_res);
				end else begin
					foreach (fresh_words[k]) begin
						expected_words.insert(expected_words.size(), fresh_words[k]);
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin : receiver
		int n;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = $urandom_range(0, rx_max);
			repeat (n) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_word(command_t c, bit typ, list_word_t tres);
		int gap;
		gap = $urandom_range(0, tx_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= c.act;
		rect_x <= c.op.x;
		rect_y <= c.op.y;
		rect_width <= c.op.w;
		rect_height <= c.op.h;
		depth_order <= c.op.depth;
		source_id <= c.op.source;
		op_tag <= c.op.tag;
		typed_on <= typ;
		typed_res <= tres;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random(logic [1:0] a);
		command_t c;
		c.act = a;
		c.op = rand_op($urandom_range(0, 4) == 0);
		send_word(c, 1'b0, '0);
	endtask

	// registers change only with nothing in flight
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		wait (expected_words.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_window;
		int x, y, w, h;
		case ($urandom_range(0, 5))
			0: begin
				x = $urandom;
				y = $urandom;
				w = $urandom_range(0, 1) ? 0 : $urandom;
				h = (w == 0) ? $urandom : 0;
			end
			1: begin
				x = -32768;
				y = -32768;
				w = 65535;
				h = 65535;
			end
			2: begin
				x = 32767;
				y = 32767;
				w = 65535;
				h = 65535;
			end
			5: begin
				x = $urandom;
				y = $urandom;
				w = $urandom;
				h = $urandom;
			end
			default: begin
				x = $urandom_range(0, 300) - 150;
				y = $urandom_range(0, 300) - 150;
				w = $urandom_range(1, 200);
				h = $urandom_range(1, 200);
			end
		endcase
		write_reg(dcsort_pkg::REG_DX, 16'(x));
		write_reg(dcsort_pkg::REG_DY, 16'(y));
		write_reg(dcsort_pkg::REG_DW, 16'(w));
		write_reg(dcsort_pkg::REG_DH, 16'(h));
	endtask

	initial begin : sender
		int items, phase, n, sel;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = dcsort_pkg::ACT_ADD;
		rect_x = '0;
		rect_y = '0;
		rect_width = '0;
		rect_height = '0;
		depth_order = '0;
		source_id = '0;
		op_tag = '0;
		typed_on = 1'b0;
		typed_res = '0;

		queue_row(empty_opt_row(1'b0));
		queue_row(word_row(ACT_NONE, -1, -1, 65535, 65535, -1, 65535, 65535));
		queue_row(word_row(dcsort_pkg::ACT_ADD, -32768, -32768, 65535, 65535,
			32767, 65535, 65535));
		queue_row(word_row(dcsort_pkg::ACT_ADD, 32767, 32767, 0, 0, -32768, 0, 0));
		queue_row(word_row(dcsort_pkg::ACT_ADD, 0, 0, 1, 1, 32767, 65535, 16'h1234));
		queue_row(word_row(dcsort_pkg::ACT_ADD, 5, 5, 3, 3, 5, 3, 16'h00a1));
		queue_row(word_row(dcsort_pkg::ACT_ADD, 6, 6, 3, 3, 5, 3, 16'h00a2));
		queue_row(word_row(dcsort_pkg::ACT_ADD, 7, 7, 3, 3, 5, 2, 16'h00a3));
		queue_row(word_row(dcsort_pkg::ACT_OPT, 0, 0, 0, 0, 0, 0, 0));
		queue_row(word_row(dcsort_pkg::ACT_CLR, 0, 0, 0, 0, 0, 0, 0));
		queue_row(empty_opt_row(1'b0));
		queue_row(reg_row(dcsort_pkg::REG_DX, 0));
		queue_row(reg_row(dcsort_pkg::REG_DY, 0));
		queue_row(reg_row(dcsort_pkg::REG_DW, 100));
		queue_row(reg_row(dcsort_pkg::REG_DH, 100));
		// lone op outside the window survives: too few ops to cull
		queue_row(word_row(dcsort_pkg::ACT_ADD, 200, 200, 10, 10, 1, 1, 16'h0b01));
		queue_row(word_row(dcsort_pkg::ACT_OPT, 0, 0, 0, 0, 0, 0, 0));
		queue_row(word_row(dcsort_pkg::ACT_ADD, 50, 50, 10, 10, 0, 7, 16'h0b02));
		queue_row(word_row(dcsort_pkg::ACT_ADD, 100, 0, 5, 5, -1, 7, 16'h0b03));
		queue_row(word_row(dcsort_pkg::ACT_ADD, 20, 20, 0, 10, -2, 7, 16'h0b04));
		queue_row(word_row(dcsort_pkg::ACT_ADD, -10, -10, 11, 11, 3, 0, 16'h0b05));
		queue_row(word_row(dcsort_pkg::ACT_OPT, 0, 0, 0, 0, 0, 0, 0));
		queue_row(word_row(dcsort_pkg::ACT_CLR, 0, 0, 0, 0, 0, 0, 0));
		queue_row(word_row(dcsort_pkg::ACT_ADD, -100, -100, 10, 10, 0, 0, 16'h0c01));
		queue_row(word_row(dcsort_pkg::ACT_ADD, 300, 300, 1, 1, 0, 0, 16'h0c02));
		queue_row(empty_opt_row(1'b0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				drain();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_word(plan[i].cmd, plan[i].typed, plan[i].res);
			end
		end

		items = 0;
		phase = 0;
		while (items < RANDOM_ITEMS) begin
			drain();
			tx_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
			rx_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
			set_window();
			if (phase == 0) begin
				n = OP_SLOTS + 2;
			end else if ($urandom_range(0, 5) == 0) begin
				n = $urandom_range(20, OP_SLOTS);
			end else begin
				n = $urandom_range(0, 8);
			end
			if (phase == 0 || $urandom_range(0, 2) == 0) begin
				send_random(dcsort_pkg::ACT_CLR);
				items++;
			end
			repeat (n) begin
				// the first phase only adds, so the store overfills
				sel = (phase == 0) ? 2 : int'($urandom_range(0, 11));
				case (sel)
					0: send_random(ACT_NONE);
					1: send_random(dcsort_pkg::ACT_CLR);
					default: send_random(dcsort_pkg::ACT_ADD);
				endcase
				items++;
			end
			send_random(dcsort_pkg::ACT_OPT);
			items++;
			if ($urandom_range(0, 4) == 0) begin
				send_random(dcsort_pkg::ACT_OPT);
				items++;
			end
			phase++;
		end

		drain();
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
